/* hw/rtl/spfs_pkg.sv */
// ----------------------------------------------------------------------------
// spfs_pkg: shared types and constants for the site permute block
// Register indexes, mode and kind codes, and the item that travels from the
// front part to the back part through the queue.
// ----------------------------------------------------------------------------
package spfs_pkg;

	// Defaults for the top level parameters.
	localparam int MAX_SITES_DEF = 32;
	localparam int MAX_OPS_DEF   = 2;
	localparam int MAX_COUNT_DEF = 16;

	// Field widths fixed by the ports.
	localparam int BASIS_W  = 64;
	localparam int SITE_W   = 5;
	localparam int COUNT_W  = 4;
	localparam int NSITES_W = 6;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	// A site index of SITE_W bits can name at most this many sites.
	localparam int SITE_LIMIT = 2 ** SITE_W;

	// Depth of the queue between front and back.
	localparam int QDEPTH  = 2;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam int QPTR_W  = $clog2(QDEPTH);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODEL_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SITES  = 1'd1;

	// Model modes; the fourth code behaves as plain mode.
	localparam logic [MODE_W-1:0] MODE_PLAIN    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FERMI    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SPIN_ONE = 2'd2;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_APPLY = 1'b1;

	typedef logic [SITE_W-1:0] site_t;

	// One apply item with the map row that belongs to it.
	typedef struct packed {
		logic                        identity;
		logic [BASIS_W-1:0]          basis;
		site_t [SITE_LIMIT-1:0]      srcs;
	} entry_t;

endpackage

/* hw/rtl/site_permute_with_fermion_sign.sv */
// ----------------------------------------------------------------------------
// site_permute_with_fermion_sign: lattice site permutation with fermion sign
// Permutes the occupation bits of a basis word by a stored site map and
// reports the sign of the reordering in fermionic mode.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------
// input    | start, busy           | kind, basis, repeat_count, op_index,
//          |                       | dest_site, source_site
// result   | done (one cycle)      | permuted_basis, sign_negative
// config   | cfg_we                | cfg_index, cfg_wdata
//
// One item is taken every cycle. An apply item passes the map read register,
// the queue and the first back stage before done is registered together with
// its result; a load item gives none and its entry is visible to an apply
// taken in the next cycle. The rate is set by the map RAM port, one access per
// cycle, shared by loads and applies. The receiver cannot stall, so busy only
// guards the short queue between the map read and the permutation stages.
// Reset clears control state; the map holds nothing defined until it is loaded.
module site_permute_with_fermion_sign #(
	parameter int MAX_SITES = spfs_pkg::MAX_SITES_DEF,
	parameter int MAX_OPS   = spfs_pkg::MAX_OPS_DEF,
	parameter int MAX_COUNT = spfs_pkg::MAX_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            kind,
	input  logic [spfs_pkg::BASIS_W-1:0]    basis,
	input  logic [spfs_pkg::COUNT_W-1:0]    repeat_count,
	input  logic                            op_index,
	input  logic [spfs_pkg::SITE_W-1:0]     dest_site,
	input  logic [spfs_pkg::SITE_W-1:0]     source_site,
	output logic                            done,
	output logic [spfs_pkg::BASIS_W-1:0]    permuted_basis,
	output logic                            sign_negative,
	input  logic                            cfg_we,
	input  logic [spfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import spfs_pkg::*;

	logic [MODE_W-1:0]   model_mode_q;
	logic [NSITES_W-1:0] num_sites_q;

	logic                push;
	entry_t              push_entry;
	logic                head_valid;
	entry_t              head_entry;
	logic [QCNT_W-1:0]   q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_mode_q <= MODE_PLAIN;
			num_sites_q  <= NSITES_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODEL_MODE: model_mode_q <= cfg_wdata[MODE_W-1:0];
				REG_NUM_SITES:  num_sites_q  <= cfg_wdata[NSITES_W-1:0];
				default: ;
			endcase
		end
	end

	spfs_front #(
		.MAX_SITES (MAX_SITES),
		.MAX_OPS   (MAX_OPS),
		.MAX_COUNT (MAX_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.basis        (basis),
		.repeat_count (repeat_count),
		.op_index     (op_index),
		.dest_site    (dest_site),
		.source_site  (source_site),
		.q_count      (q_count),
		.push         (push),
		.push_entry   (push_entry)
	);

	spfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (head_valid),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.count      (q_count)
	);

	spfs_back #(
		.MAX_SITES (MAX_SITES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (head_valid),
		.in_entry       (head_entry),
		.model_mode     (model_mode_q),
		.num_sites      (num_sites_q),
		.done           (done),
		.permuted_basis (permuted_basis),
		.sign_negative  (sign_negative)
	);

endmodule

/* hw/rtl/spfs_ram.sv */
// ----------------------------------------------------------------------------
// spfs_ram: generic single port RAM
// One address a cycle; a write also reads the old word, and the read data is registered.
// ----------------------------------------------------------------------------
module spfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* hw/rtl/spfs_front.sv */
// ----------------------------------------------------------------------------
// spfs_front: item intake and map storage
// Accepts items, writes map entries for loads, reads the whole map row of an
// apply item and hands the apply item with its row to the queue.
// ----------------------------------------------------------------------------
module spfs_front #(
	parameter int MAX_SITES = 32,
	parameter int MAX_OPS   = 2,
	parameter int MAX_COUNT = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [spfs_pkg::BASIS_W-1:0]      basis,
	input  logic [spfs_pkg::COUNT_W-1:0]      repeat_count,
	input  logic                              op_index,
	input  logic [spfs_pkg::SITE_W-1:0]       dest_site,
	input  logic [spfs_pkg::SITE_W-1:0]       source_site,
	input  logic [spfs_pkg::QCNT_W-1:0]       q_count,
	output logic                              push,
	output spfs_pkg::entry_t                  push_entry
);
	import spfs_pkg::*;

	localparam int ROWS  = MAX_OPS * MAX_COUNT;
	localparam int ROW_W = $clog2(ROWS);

	logic               accept;
	logic [6:0]         cnt_mod;
	logic               op_mod;
	logic [9:0]         row_full;
	logic [ROW_W-1:0]   row;
	logic [QCNT_W:0]    level;
	site_t              lane_rdata [SITE_LIMIT];

	logic               valid_s1;
	logic               ident_s1;
	logic [BASIS_W-1:0] basis_s1;

	// Room is counted with the item already in flight and the pop that the
	// back part always makes when the queue holds something.
	always_comb begin
		level = {1'b0, q_count} + {{QCNT_W{1'b0}}, valid_s1}
			- {{QCNT_W{1'b0}}, (q_count != '0)};
		busy = (level >= (QCNT_W + 1)'(QDEPTH));
	end

	assign accept = start && !busy;

	// The count is folded into its range by repeated subtraction, and the operator is
	// taken as zero when MAX_OPS is one; the loop suffices whenever MAX_COUNT is at least two.
	always_comb begin
		cnt_mod = {3'b000, repeat_count};
		for (int k = 0; k < 8; k++) begin
			if (cnt_mod >= 7'(MAX_COUNT)) begin
				cnt_mod = cnt_mod - 7'(MAX_COUNT);
			end
		end
		op_mod   = (MAX_OPS > 1) ? op_index : 1'b0;
		row_full = (op_mod ? 10'(MAX_COUNT) : 10'd0) + {3'b000, cnt_mod};
		row      = row_full[ROW_W-1:0];
	end

	for (genvar g = 0; g < SITE_LIMIT; g++) begin : g_lane
		if (g < MAX_SITES) begin : g_ram
			logic lane_we;
			assign lane_we = accept && (kind == KIND_LOAD) && (dest_site == SITE_W'(g));
			spfs_ram #(
				.WIDTH (SITE_W),
				.DEPTH (ROWS)
			) u_ram (
				.clk   (clk),
				.we    (lane_we),
				.addr  (row),
				.wdata (source_site),
				.rdata (lane_rdata[g])
			);
		end else begin : g_unused
			assign lane_rdata[g] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (kind == KIND_APPLY);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ident_s1 <= (repeat_count == '0);
			basis_s1 <= basis;
		end
	end

	always_comb begin
		push                = valid_s1;
		push_entry.identity = ident_s1;
		push_entry.basis    = basis_s1;
		for (int d = 0; d < SITE_LIMIT; d++) begin
			push_entry.srcs[d] = lane_rdata[d];
		end
	end

endmodule

/* hw/rtl/spfs_queue.sv */
// ----------------------------------------------------------------------------
// spfs_queue: short queue between front and back
// Holds apply items with their map rows until the back part takes them.
// ----------------------------------------------------------------------------
module spfs_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  spfs_pkg::entry_t            push_entry,
	input  logic                        pop,
	output logic                        head_valid,
	output spfs_pkg::entry_t            head_entry,
	output logic [spfs_pkg::QCNT_W-1:0] count
);
	import spfs_pkg::*;

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* hw/rtl/spfs_back.sv */
// ----------------------------------------------------------------------------
// spfs_back: permutation and sign
// First stage gathers the source bits and the pairwise inversions of the
// occupied sites; second stage assembles the word and folds the parity.
// ----------------------------------------------------------------------------
module spfs_back #(
	parameter int MAX_SITES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  spfs_pkg::entry_t              in_entry,
	input  logic [spfs_pkg::MODE_W-1:0]   model_mode,
	input  logic [spfs_pkg::NSITES_W-1:0] num_sites,
	output logic                          done,
	output logic [spfs_pkg::BASIS_W-1:0]  permuted_basis,
	output logic                          sign_negative
);
	import spfs_pkg::*;

	localparam int PAIRS_W = MAX_SITES * MAX_SITES;

	logic [NSITES_W-1:0]  n_eff;
	logic [BASIS_W-1:0]   shifted;
	logic [MAX_SITES-1:0] lo;
	logic [MAX_SITES-1:0] hi;
	logic [PAIRS_W-1:0]   inv;

	logic                 valid_s2;
	logic                 ident_s2;
	logic [BASIS_W-1:0]   basis_s2;
	logic [MAX_SITES-1:0] lo_s2;
	logic [MAX_SITES-1:0] hi_s2;
	logic [PAIRS_W-1:0]   inv_s2;
	logic [NSITES_W-1:0]  n_s2;

	logic [BASIS_W-1:0]   word;
	logic                 parity;

	always_comb begin
		n_eff = (num_sites > NSITES_W'(MAX_SITES)) ? NSITES_W'(MAX_SITES) : num_sites;
		// The upper half of a spin-one word starts at bit n_eff.
		shifted = in_entry.basis >> n_eff;
		for (int d = 0; d < MAX_SITES; d++) begin
			lo[d] = (NSITES_W'(d) < n_eff) && in_entry.basis[{1'b0, in_entry.srcs[d]}];
			hi[d] = (NSITES_W'(d) < n_eff) && shifted[{1'b0, in_entry.srcs[d]}];
		end
		// An inversion is an occupied pair whose sources run in reverse order.
		inv = '0;
		for (int i = 0; i < MAX_SITES; i++) begin
			for (int j = i + 1; j < MAX_SITES; j++) begin
				inv[i * MAX_SITES + j] = lo[i] && lo[j]
					&& (in_entry.srcs[i] > in_entry.srcs[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			ident_s2 <= in_entry.identity;
			basis_s2 <= in_entry.basis;
			lo_s2    <= lo;
			hi_s2    <= hi;
			inv_s2   <= inv;
			n_s2     <= n_eff;
		end
	end

	always_comb begin
		if (ident_s2) begin
			word   = basis_s2;
			parity = 1'b0;
		end else begin
			word = BASIS_W'(lo_s2);
			if (model_mode == MODE_SPIN_ONE) begin
				word = word | (BASIS_W'(hi_s2) << n_s2);
			end
			parity = (model_mode == MODE_FERMI) && (^inv_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			permuted_basis <= word;
			sign_negative  <= parity;
		end
	end

endmodule
